>>> rtl/rrw_pkg.sv
package rrw_pkg;

  localparam int MAX_SLOTS = 17;
  localparam int ID_BITS   = 8;
  localparam int PTR_W     = $clog2(MAX_SLOTS);
  localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
  localparam int SZ_W      = PTR_W + 1;

  typedef enum logic [1:0] {
    FUNC_INSERT,
    FUNC_SEND,
    FUNC_REPLY,
    FUNC_TIMEOUT
  } func_t;

  typedef enum logic [2:0] {
    EV_TRANSMIT,
    EV_COMPLETED,
    EV_DISCARDED,
    EV_REQUEUED,
    EV_DUPLICATE
  } event_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_TIMEOUT,
    ST_UNEXPECTED,
    ST_DUPLICATE
  } status_t;

  localparam logic [1:0] REG_ALLOWED = 2'd0;
  localparam logic [1:0] REG_RING    = 2'd1;
  localparam logic [1:0] REG_UNIT    = 2'd2;

  typedef struct packed {
    logic [3:0] allowed;
    logic [4:0] ring_slots;
    logic [7:0] unit_id;
  } cfg_t;

  typedef struct packed {
    logic [7:0]         tag;
    logic [ID_BITS-1:0] msg_id;
    logic               wants_reply;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEND,
    S_HEAD,
    S_SCAN,
    S_RQ_ISSUE,
    S_RQ,
    S_MATCH
  } state_t;

  // Effective ring size: register clamped to [2, MAX_SLOTS].
  function automatic logic [SZ_W-1:0] ring_size(input logic [4:0] rs);
    logic [SZ_W-1:0] n;
    if (rs < 5'd2) begin
      n = SZ_W'(2);
    end else if (32'(rs) > MAX_SLOTS) begin
      n = SZ_W'(MAX_SLOTS);
    end else begin
      n = SZ_W'(rs);
    end
    return n;
  endfunction

  function automatic logic [PTR_W-1:0] succ(input logic [PTR_W-1:0] p,
                                           input logic [SZ_W-1:0] size);
    logic [SZ_W-1:0] n;
    n = {1'b0, p} + SZ_W'(1);
    return (n >= size) ? '0 : n[PTR_W-1:0];
  endfunction

endpackage

>>> rtl/rrw_ram.sv
module rrw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/rrw_ctrl.sv
module rrw_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rrw_pkg::cfg_t               cfg,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  func,
  input  logic [7:0]                  req_tag,
  input  logic                        wants_reply,
  input  logic [7:0]                  reply_id,
  output logic                        ram_we,
  output logic [rrw_pkg::PTR_W-1:0]   ram_waddr,
  output rrw_pkg::slot_t              ram_wdata,
  output logic [rrw_pkg::PTR_W-1:0]   ram_raddr,
  input  rrw_pkg::slot_t              ram_rdata,
  output logic                        out_valid,
  output logic [2:0]                  out_event_kind,
  output logic [7:0]                  out_tag,
  output logic [7:0]                  out_msg_id,
  output logic [1:0]                  out_recv_status,
  output logic [7:0]                  out_notify_unit,
  output logic                        out_last
);
  import rrw_pkg::*;

  state_t             state_r, state_nxt;
  logic [PTR_W-1:0]   ins_r, ins_nxt, snd_r, snd_nxt, rcv_r, rcv_nxt;
  logic [PTR_W-1:0]   scan_ptr_r, scan_ptr_nxt;
  logic [CNT_W-1:0]   q_r, q_nxt, f_r, f_nxt;
  logic [CNT_W-1:0]   scan_idx_r, scan_idx_nxt, pos_r, pos_nxt;
  logic [4:0]         tc_r, tc_nxt;
  logic [ID_BITS-1:0] last_id_r, last_id_nxt, rid_r, rid_nxt;
  func_t              func_r, func_nxt;

  logic               ov_r, ov_nxt, ol_r, ol_nxt;
  event_t             ok_r, ok_nxt;
  logic [7:0]         ot_r, ot_nxt, oi_r, oi_nxt, on_r, on_nxt;
  status_t            os_r, os_nxt;

  logic [SZ_W-1:0]    size;
  logic               accept, head_match, scan_match, scan_end, discard;
  logic [ID_BITS-1:0] new_id;
  logic [4:0]         tc_inc;
  logic [CNT_W-1:0]   idx_inc;
  logic               do_to, to_last;
  status_t            to_status;

  assign size       = ring_size(cfg.ring_slots);
  assign accept     = start && (state_r == S_IDLE);
  assign busy       = (state_r != S_IDLE);
  assign new_id     = last_id_r + ID_BITS'(1);
  assign tc_inc     = tc_r + 5'd1;
  assign discard    = tc_inc > {1'b0, cfg.allowed};
  assign head_match = (ram_rdata.msg_id == rid_r);
  assign scan_match = head_match;
  assign idx_inc    = scan_idx_r + CNT_W'(1);
  assign scan_end   = (idx_inc == f_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (func_t'(func))
            FUNC_INSERT: state_nxt = S_IDLE;
            FUNC_SEND:   state_nxt = (q_r != '0) ? S_SEND : S_IDLE;
            default:     state_nxt = (f_r != '0) ? S_HEAD : S_IDLE;
          endcase
        end
      end
      S_SEND: state_nxt = S_IDLE;
      S_HEAD: begin
        if (!ram_rdata.wants_reply || func_r == FUNC_TIMEOUT || head_match ||
            f_r == CNT_W'(1)) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_match) begin
          state_nxt = S_RQ_ISSUE;
        end else if (scan_end) begin
          state_nxt = S_IDLE;
        end
      end
      S_RQ_ISSUE: state_nxt = (pos_r == '0) ? S_MATCH : S_RQ;
      S_RQ:       state_nxt = S_RQ_ISSUE;
      S_MATCH:    state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Datapath, memory port and result register.
  always_comb begin
    ins_nxt      = ins_r;
    snd_nxt      = snd_r;
    rcv_nxt      = rcv_r;
    q_nxt        = q_r;
    f_nxt        = f_r;
    tc_nxt       = tc_r;
    last_id_nxt  = last_id_r;
    rid_nxt      = rid_r;
    func_nxt     = func_r;
    scan_ptr_nxt = scan_ptr_r;
    scan_idx_nxt = scan_idx_r;
    pos_nxt      = pos_r;
    ov_nxt       = 1'b0;
    ok_nxt       = ok_r;
    ot_nxt       = ot_r;
    oi_nxt       = oi_r;
    os_nxt       = os_r;
    on_nxt       = on_r;
    ol_nxt       = ol_r;
    ram_we       = 1'b0;
    ram_waddr    = ins_r;
    ram_wdata    = '{tag: req_tag, msg_id: new_id, wants_reply: wants_reply};
    ram_raddr    = rcv_r;
    do_to        = 1'b0;
    to_last      = 1'b1;
    to_status    = ST_TIMEOUT;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          func_nxt = func_t'(func);
          rid_nxt  = ID_BITS'(reply_id);
          if (func_t'(func) == FUNC_SEND) begin
            ram_raddr = snd_r;
          end
          if (func_t'(func) == FUNC_INSERT &&
              ({1'b0, q_r} + {1'b0, f_r}) < (CNT_W + 1)'(size)) begin
            ram_we      = 1'b1;
            last_id_nxt = new_id;
            ins_nxt     = succ(ins_r, size);
            q_nxt       = q_r + CNT_W'(1);
          end
        end
      end
      S_SEND: begin
        ov_nxt  = 1'b1;
        ok_nxt  = EV_TRANSMIT;
        ot_nxt  = ram_rdata.tag;
        oi_nxt  = 8'(ram_rdata.msg_id);
        os_nxt  = ST_OK;
        ol_nxt  = 1'b1;
        f_nxt   = f_r + CNT_W'(1);
        q_nxt   = q_r - CNT_W'(1);
        snd_nxt = succ(snd_r, size);
      end
      S_HEAD: begin
        if (!ram_rdata.wants_reply || (func_r != FUNC_TIMEOUT && head_match)) begin
          ov_nxt  = 1'b1;
          ok_nxt  = EV_COMPLETED;
          ot_nxt  = ram_rdata.tag;
          oi_nxt  = 8'(ram_rdata.msg_id);
          os_nxt  = ST_OK;
          ol_nxt  = 1'b1;
          f_nxt   = f_r - CNT_W'(1);
          rcv_nxt = succ(rcv_r, size);
          if (ram_rdata.wants_reply && tc_r != '0) begin
            tc_nxt = tc_r - 5'd1;
          end
        end else if (func_r == FUNC_TIMEOUT) begin
          do_to = 1'b1;
        end else if (f_r == CNT_W'(1)) begin
          ov_nxt = 1'b1;
          ok_nxt = EV_DUPLICATE;
          ot_nxt = '0;
          oi_nxt = 8'(rid_r);
          os_nxt = ST_DUPLICATE;
          ol_nxt = 1'b1;
        end else begin
          ram_raddr    = succ(rcv_r, size);
          scan_ptr_nxt = succ(rcv_r, size);
          scan_idx_nxt = CNT_W'(1);
        end
      end
      S_SCAN: begin
        if (scan_match) begin
          pos_nxt = scan_idx_r;
        end else if (scan_end) begin
          ov_nxt = 1'b1;
          ok_nxt = EV_DUPLICATE;
          ot_nxt = '0;
          oi_nxt = 8'(rid_r);
          os_nxt = ST_DUPLICATE;
          ol_nxt = 1'b1;
        end else begin
          ram_raddr    = succ(scan_ptr_r, size);
          scan_ptr_nxt = succ(scan_ptr_r, size);
          scan_idx_nxt = idx_inc;
        end
      end
      S_RQ_ISSUE: ram_raddr = rcv_r;
      S_RQ: begin
        do_to     = 1'b1;
        to_last   = 1'b0;
        to_status = ST_UNEXPECTED;
        pos_nxt   = pos_r - CNT_W'(1);
      end
      S_MATCH: begin
        ov_nxt  = 1'b1;
        ok_nxt  = EV_COMPLETED;
        ot_nxt  = ram_rdata.tag;
        oi_nxt  = 8'(ram_rdata.msg_id);
        os_nxt  = ST_UNEXPECTED;
        ol_nxt  = 1'b1;
        f_nxt   = f_r - CNT_W'(1);
        rcv_nxt = succ(rcv_r, size);
      end
      default: ;
    endcase

    // Head timed out or passed over by a later reply: discard past the limit, otherwise requeue with a fresh id.
    if (do_to) begin
      ov_nxt  = 1'b1;
      ot_nxt  = ram_rdata.tag;
      os_nxt  = to_status;
      ol_nxt  = to_last;
      f_nxt   = f_r - CNT_W'(1);
      rcv_nxt = succ(rcv_r, size);
      if (discard) begin
        ok_nxt = EV_DISCARDED;
        oi_nxt = 8'(ram_rdata.msg_id);
        tc_nxt = '0;
      end else begin
        ok_nxt      = EV_REQUEUED;
        oi_nxt      = 8'(new_id);
        tc_nxt      = tc_inc;
        ram_we      = 1'b1;
        ram_wdata   = '{tag: ram_rdata.tag, msg_id: new_id,
                        wants_reply: ram_rdata.wants_reply};
        last_id_nxt = new_id;
        ins_nxt     = succ(ins_r, size);
        q_nxt       = q_r + CNT_W'(1);
      end
    end
    if (ov_nxt) begin
      on_nxt = cfg.unit_id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ins_r     <= '0;
      snd_r     <= '0;
      rcv_r     <= '0;
      q_r       <= '0;
      f_r       <= '0;
      tc_r      <= '0;
      last_id_r <= '1;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ins_r     <= ins_nxt;
      snd_r     <= snd_nxt;
      rcv_r     <= rcv_nxt;
      q_r       <= q_nxt;
      f_r       <= f_nxt;
      tc_r      <= tc_nxt;
      last_id_r <= last_id_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rid_r      <= rid_nxt;
    func_r     <= func_nxt;
    scan_ptr_r <= scan_ptr_nxt;
    scan_idx_r <= scan_idx_nxt;
    pos_r      <= pos_nxt;
    ok_r       <= ok_nxt;
    ot_r       <= ot_nxt;
    oi_r       <= oi_nxt;
    os_r       <= os_nxt;
    on_r       <= on_nxt;
    ol_r       <= ol_nxt;
  end

  assign out_valid       = ov_r;
  assign out_event_kind  = ok_r;
  assign out_tag         = ot_r;
  assign out_msg_id      = oi_r;
  assign out_recv_status = os_r;
  assign out_notify_unit = on_r;
  assign out_last        = ol_r;

endmodule

>>> rtl/retransmit_ring_window.sv
// Channel   Direction  Handshake                 Payload
// input     in         start / busy              in_func, in_req_tag, in_wants_reply,
//                                                in_reply_id
// result    out        out_valid strobe          out_event_kind, out_tag, out_msg_id,
//                                                out_recv_status, out_notify_unit, out_last
// config    in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// An insert is settled in the idle state. A send reads the slot at the send pointer; a reply
// or timeout reads the head slot, and an unexpected reply id then scans the in-flight slots,
// requeues each earlier slot and completes the match once the id is found. Each result is
// registered and shows in the cycle after the state that makes it. Reset is synchronous and
// clears pointers, counts and the result strobe and sets the last id to all ones; result
// fields and the slot memory are not cleared. The receiver cannot stall: every result
// strobe must be taken.
module retransmit_ring_window (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_func,
  input  logic [7:0] in_req_tag,
  input  logic       in_wants_reply,
  input  logic [7:0] in_reply_id,
  output logic       out_valid,
  output logic [2:0] out_event_kind,
  output logic [7:0] out_tag,
  output logic [7:0] out_msg_id,
  output logic [1:0] out_recv_status,
  output logic [7:0] out_notify_unit,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import rrw_pkg::*;

  cfg_t             cfg_r;
  logic             ram_we;
  logic [PTR_W-1:0] ram_waddr, ram_raddr;
  slot_t            ram_wdata, ram_rdata;

  // Configuration writes are always taken; indexes beyond the list are ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.allowed    <= 4'd3;
      cfg_r.ring_slots <= 5'd17;
      cfg_r.unit_id    <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ALLOWED: cfg_r.allowed    <= cfg_data[3:0];
        REG_RING:    cfg_r.ring_slots <= cfg_data[4:0];
        REG_UNIT:    cfg_r.unit_id    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Slot tag, message id and reply flag share one memory word.
  rrw_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(MAX_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rrw_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .start           (start),
    .busy            (busy),
    .func            (in_func),
    .req_tag         (in_req_tag),
    .wants_reply     (in_wants_reply),
    .reply_id        (in_reply_id),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .ram_raddr       (ram_raddr),
    .ram_rdata       (ram_rdata),
    .out_valid       (out_valid),
    .out_event_kind  (out_event_kind),
    .out_tag         (out_tag),
    .out_msg_id      (out_msg_id),
    .out_recv_status (out_recv_status),
    .out_notify_unit (out_notify_unit),
    .out_last        (out_last)
  );

endmodule

>>> rtl/rrw_checker.sv
module rrw_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [1:0] in_func,
  input logic       out_valid,
  input logic [2:0] out_event_kind,
  input logic [7:0] out_tag,
  input logic [1:0] out_recv_status,
  input logic       out_last
);
  import rrw_pkg::*;

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid)
    else $error("block not quiet after reset");

  a_insert_silent: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_func == FUNC_INSERT |=> !out_valid && !busy)
    else $error("insert produced a result or held the block");

  a_transmit_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == EV_TRANSMIT |-> out_last && out_recv_status == ST_OK)
    else $error("transmit result malformed");

  a_duplicate: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == EV_DUPLICATE |->
      out_last && out_tag == 8'd0 && out_recv_status == ST_DUPLICATE)
    else $error("duplicate result malformed");

  a_requeue_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == EV_REQUEUED |->
      out_recv_status == ST_TIMEOUT || out_recv_status == ST_UNEXPECTED)
    else $error("requeue carries wrong status");

endmodule

bind retransmit_ring_window rrw_checker u_rrw_checker (.*);

>>> bench/retransmit_ring_window_tb.sv
`timescale 1ns / 100ps

module retransmit_ring_window_tb;
  import rrw_pkg::*;

  // One expected notification from the block.
  typedef struct {
    event_t     kind;
    logic [7:0] tag;
    logic [7:0] msg_id;
    status_t    status;
    logic [7:0] unit;
    logic       last;
  } note_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] in_func = FUNC_INSERT;
  logic [7:0] in_req_tag = '0;
  logic       in_wants_reply = 1'b0;
  logic [7:0] in_reply_id = '0;
  logic       out_valid;
  logic [2:0] out_event_kind;
  logic [7:0] out_tag;
  logic [7:0] out_msg_id;
  logic [1:0] out_recv_status;
  logic [7:0] out_notify_unit;
  logic       out_last;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = REG_ALLOWED;
  logic [7:0] cfg_data = '0;

  retransmit_ring_window dut (.*);

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Our own copy of the ring: slot contents, pointers, counts and registers.
  logic [7:0] ring_tag [MAX_SLOTS];
  logic [7:0] ring_id  [MAX_SLOTS];
  logic       ring_wr  [MAX_SLOTS];
  int         ins_ptr, snd_ptr, rcv_ptr;
  int         n_queued, n_flight, n_timeouts;
  logic [7:0] last_id;
  int         lim_timeouts;
  int         slots_reg;
  logic [7:0] unit_reg;

  note_t pending_notes[$];  // notifications still owed by the block
  note_t step_notes[$];     // notifications caused by the item being predicted
  int    errors = 0;
  int    cycles = 0;

  // The ring size register is clamped to [2, MAX_SLOTS].
  function automatic int ring_len();
    if (slots_reg < 2) return 2;
    if (slots_reg > MAX_SLOTS) return MAX_SLOTS;
    return slots_reg;
  endfunction

  // Pointers that reach or pass the end of the ring wrap to slot 0.
  function automatic int next_slot(int p);
    return (p + 1 >= ring_len()) ? 0 : p + 1;
  endfunction

  function automatic void add_note(event_t kind, logic [7:0] tag, logic [7:0] id,
                                   status_t st);
    note_t n;
    n.kind = kind;
    n.tag = tag;
    n.msg_id = id;
    n.status = st;
    n.unit = unit_reg;
    n.last = 1'b0;
    step_notes.push_back(n);
  endfunction

  // A new or requeued request takes the next message id; ids wrap at 8 bits.
  function automatic void enqueue_request(logic [7:0] tag, logic wr);
    last_id = last_id + 8'd1;
    ring_tag[ins_ptr] = tag;
    ring_id[ins_ptr] = last_id;
    ring_wr[ins_ptr] = wr;
    ins_ptr = next_slot(ins_ptr);
    n_queued++;
  endfunction

  function automatic void retire_head();
    n_flight--;
    rcv_ptr = next_slot(rcv_ptr);
  endfunction

  // The head has timed out: it goes back into the queue under a fresh id,
  // unless the timeout count, which a matching head reply lowers, now exceeds the limit.
  function automatic void expire_head(status_t st);
    logic [7:0] tag;
    logic [7:0] id;
    logic       wr;
    tag = ring_tag[rcv_ptr];
    id = ring_id[rcv_ptr];
    wr = ring_wr[rcv_ptr];
    n_timeouts++;
    if (n_timeouts > lim_timeouts) begin
      add_note(EV_DISCARDED, tag, id, st);
      retire_head();
      n_timeouts = 0;
    end else begin
      retire_head();
      enqueue_request(tag, wr);
      add_note(EV_REQUEUED, tag, last_id, st);
    end
  endfunction

  // Works out what one accepted item makes the block report, and queues it.
  function automatic void predict_notes(func_t f, logic [7:0] tag, logic wr,
                                        logic [7:0] rid);
    int p;
    int pos;
    bit found;
    step_notes.delete();
    if (f == FUNC_INSERT) begin
      if (n_queued + n_flight < ring_len()) enqueue_request(tag, wr);
    end else if (f == FUNC_SEND) begin
      if (n_queued > 0) begin
        add_note(EV_TRANSMIT, ring_tag[snd_ptr], ring_id[snd_ptr], ST_OK);
        n_flight++;
        n_queued--;
        snd_ptr = next_slot(snd_ptr);
      end
    end else if (n_flight > 0) begin
      if (!ring_wr[rcv_ptr]) begin
        // A request that wants no reply is done by any receive event.
        add_note(EV_COMPLETED, ring_tag[rcv_ptr], ring_id[rcv_ptr], ST_OK);
        retire_head();
      end else if (f == FUNC_TIMEOUT) begin
        expire_head(ST_TIMEOUT);
      end else if (ring_id[rcv_ptr] == rid) begin
        add_note(EV_COMPLETED, ring_tag[rcv_ptr], ring_id[rcv_ptr], ST_OK);
        retire_head();
        if (n_timeouts > 0) n_timeouts--;
      end else begin
        // Unknown id: look for it among the in-flight slots.
        p = rcv_ptr;
        pos = 0;
        found = 1'b0;
        for (int i = 0; i < n_flight; i++) begin
          if (ring_id[p] == rid) begin
            found = 1'b1;
            pos = i;
            break;
          end
          p = next_slot(p);
        end
        if (found) begin
          for (int i = 0; i < pos; i++) expire_head(ST_UNEXPECTED);
          add_note(EV_COMPLETED, ring_tag[rcv_ptr], ring_id[rcv_ptr], ST_UNEXPECTED);
          retire_head();
        end else begin
          add_note(EV_DUPLICATE, 8'd0, rid, ST_DUPLICATE);
        end
      end
    end
    if (step_notes.size() > 0) step_notes[step_notes.size() - 1].last = 1'b1;
    foreach (step_notes[i]) pending_notes.push_back(step_notes[i]);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Every strobe is taken at the rising edge that ends its cycle and compared
  // with the oldest notification still owed.
  always @(posedge clk) begin
    note_t n;
    if (rst_n && out_valid) begin
      if (pending_notes.size() == 0) begin
        report_mismatch("unexpected result (kind)", out_event_kind, -1);
      end else begin
        n = pending_notes.pop_front();
        if (out_event_kind != n.kind) report_mismatch("event_kind", out_event_kind, n.kind);
        if (out_tag != n.tag) report_mismatch("tag", out_tag, n.tag);
        if (out_msg_id != n.msg_id) report_mismatch("msg_id", out_msg_id, n.msg_id);
        if (out_recv_status != n.status)
          report_mismatch("recv_status", out_recv_status, n.status);
        if (out_notify_unit != n.unit)
          report_mismatch("notify_unit", out_notify_unit, n.unit);
        if (out_last != n.last) report_mismatch("last", out_last, n.last);
      end
    end
  end

  // Watchdog: far more than the slowest correct run could need.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= 400000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Presents one item from a falling edge and holds it until the block takes
  // it. start stays high afterward, so the caller's next step must either
  // present another item or lower start at the following falling edge.
  task automatic send_item(func_t f, logic [7:0] tag, logic wr, logic [7:0] rid);
    @(negedge clk);
    start = 1'b1;
    in_func = f;
    in_req_tag = tag;
    in_wants_reply = wr;
    in_reply_id = rid;
    do @(posedge clk); while (busy);
    predict_notes(f, tag, wr, rid);
  endtask

  task automatic pause_sender(int n);
    @(negedge clk);
    start = 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Waits until every owed notification has come, then lets the longest scan
  // run out, since an item that gives no result may still be in progress.
  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    while (pending_notes.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // Empties the ring by sending everything and then answering each head with
  // its own id. This keeps a later resize from exposing slots never written.
  task automatic empty_ring();
    while (n_queued > 0 || n_flight > 0) begin
      if (n_queued > 0) send_item(FUNC_SEND, 8'($urandom), 1'($urandom), 8'($urandom));
      else send_item(FUNC_REPLY, 8'($urandom), 1'($urandom), ring_id[rcv_ptr]);
    end
    settle();
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ALLOWED: lim_timeouts = int'(data[3:0]);
      REG_RING:    slots_reg = int'(data[4:0]);
      REG_UNIT:    unit_reg = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Directed: empty-ring cases, a full exchange, an out-of-order reply that
  // requeues earlier slots, and a duplicate reply.
  task automatic test_basic_exchange();
    send_item(FUNC_SEND, 8'h00, 1'b0, 8'h00);     // nothing queued
    send_item(FUNC_REPLY, 8'h00, 1'b0, 8'h00);    // nothing in flight
    send_item(FUNC_TIMEOUT, 8'h00, 1'b0, 8'h00);  // nothing in flight
    send_item(FUNC_INSERT, 8'hFF, 1'b1, 8'h00);
    send_item(FUNC_INSERT, 8'h00, 1'b0, 8'hFF);
    send_item(FUNC_INSERT, 8'h5A, 1'b1, 8'h00);
    repeat (3) send_item(FUNC_SEND, 8'h00, 1'b0, 8'h00);
    // Id 2 sits behind two other slots: both are requeued, then it completes.
    send_item(FUNC_REPLY, 8'h00, 1'b0, 8'd2);
    repeat (2) send_item(FUNC_SEND, 8'h00, 1'b0, 8'h00);
    send_item(FUNC_REPLY, 8'h00, 1'b0, 8'hFF);    // unknown id: duplicate
    send_item(FUNC_TIMEOUT, 8'h00, 1'b0, 8'h00);
    empty_ring();
  endtask

  // Directed: smallest ring with a full-ring insert, and a zero timeout limit
  // so that the first timeout discards the head.
  task automatic test_ring_limits();
    write_reg(REG_RING, 8'd1);
    write_reg(REG_ALLOWED, 8'd0);
    write_reg(REG_UNIT, 8'hFF);
    send_item(FUNC_INSERT, 8'h11, 1'b1, 8'h00);
    send_item(FUNC_INSERT, 8'h22, 1'b1, 8'h00);
    send_item(FUNC_INSERT, 8'h33, 1'b1, 8'h00);   // ring full: ignored
    repeat (2) send_item(FUNC_SEND, 8'h00, 1'b0, 8'h00);
    send_item(FUNC_TIMEOUT, 8'h00, 1'b0, 8'h00);  // discarded at once
    send_item(FUNC_REPLY, 8'h00, 1'b0, ring_id[rcv_ptr]);
    settle();
  endtask

  // Random traffic that mostly follows the protocol: replies usually carry an
  // id that is really in flight, most often the head's. After each item the sender keeps
  // pausing while a random roll out of a hundred falls below idle_pct.
  task automatic test_random_traffic(int idle_pct, int n_items);
    int         pick;
    int         p;
    logic [7:0] rid;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      rid = 8'($urandom);
      if (n_flight > 0 && $urandom_range(99) < 85) begin
        p = rcv_ptr;
        if ($urandom_range(99) < 35) repeat ($urandom_range(n_flight - 1)) p = next_slot(p);
        rid = ring_id[p];
      end
      if (pick < 32) send_item(FUNC_INSERT, 8'($urandom), 1'($urandom), 8'($urandom));
      else if (pick < 62) send_item(FUNC_SEND, 8'($urandom), 1'($urandom), 8'($urandom));
      else if (pick < 88) send_item(FUNC_REPLY, 8'($urandom), 1'($urandom), rid);
      else send_item(FUNC_TIMEOUT, 8'($urandom), 1'($urandom), rid);
      while ($urandom_range(99) < idle_pct) pause_sender(1);
    end
    empty_ring();
  endtask

  initial begin
    ins_ptr = 0;
    snd_ptr = 0;
    rcv_ptr = 0;
    n_queued = 0;
    n_flight = 0;
    n_timeouts = 0;
    last_id = 8'hFF;
    lim_timeouts = 3;
    slots_reg = 17;
    unit_reg = 8'h00;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_basic_exchange();
    test_ring_limits();

    write_reg(REG_RING, 8'd4);
    write_reg(REG_ALLOWED, 8'($urandom_range(1, 4)));
    write_reg(REG_UNIT, 8'($urandom));
    test_random_traffic(24, 155);

    // Ring register below its range acts as a two-slot ring.
    write_reg(REG_RING, 8'd0);
    write_reg(REG_ALLOWED, 8'd0);
    write_reg(REG_UNIT, 8'h00);
    test_random_traffic(81, 150);

    // Ring register above its range acts as the full ring.
    write_reg(REG_RING, 8'd31);
    write_reg(REG_ALLOWED, 8'd15);
    write_reg(REG_UNIT, 8'($urandom));
    test_random_traffic(0, 155);

    settle();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> retransmit_ring_window.f
rtl/rrw_pkg.sv
rtl/rrw_ram.sv
rtl/rrw_ctrl.sv
rtl/retransmit_ring_window.sv
rtl/rrw_checker.sv
bench/retransmit_ring_window_tb.sv
